>>> hdl/cfuv_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and face constants for the cube-map face projector.
// Used by cfuv_div and cubemap_face_uv_project; depends on nothing else.
package cfuv_pkg;

   // Field widths fixed by the interface.
   localparam int COORD_BITS = 16;
   localparam int UV_BITS    = 16;
   localparam int FACE_BITS  = 3;

   // Internal widths: magnitude holds the most negative component exactly,
   // the numerator m +/- c spans [0, 2m], and the quotient may reach 2^UV_BITS.
   localparam int MAG_BITS  = COORD_BITS + 1;
   localparam int NUM_BITS  = MAG_BITS + 1;
   localparam int DIVD_BITS = NUM_BITS + UV_BITS;
   localparam int DIVS_BITS = MAG_BITS + 1;
   localparam int QUO_BITS  = UV_BITS + 1;

   localparam logic [UV_BITS-1:0] UV_HALF = {1'b1, {(UV_BITS - 1){1'b0}}};
   localparam logic [UV_BITS-1:0] UV_MAX  = {UV_BITS{1'b1}};

   // Face codes.
   localparam logic [FACE_BITS-1:0] FACE_POS_X = 3'd0;
   localparam logic [FACE_BITS-1:0] FACE_NEG_X = 3'd1;
   localparam logic [FACE_BITS-1:0] FACE_POS_Y = 3'd2;
   localparam logic [FACE_BITS-1:0] FACE_NEG_Y = 3'd3;
   localparam logic [FACE_BITS-1:0] FACE_POS_Z = 3'd4;
   localparam logic [FACE_BITS-1:0] FACE_NEG_Z = 3'd5;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   // Input beat.
   typedef struct packed {
      logic signed [COORD_BITS-1:0] dir_x;
      logic signed [COORD_BITS-1:0] dir_y;
      logic signed [COORD_BITS-1:0] dir_z;
   } req_type;

   // Result beat.
   typedef struct packed {
      logic [FACE_BITS-1:0] face;
      logic [UV_BITS-1:0]   tex_u;
      logic [UV_BITS-1:0]   tex_v;
      logic                 zero_dir;
   } rsp_type;

   // Sideband that rides along the divider pipeline.
   typedef struct packed {
      logic [FACE_BITS-1:0] face;
      logic                 zero_dir;
   } cfuv_tag_type;

   // Per-face choice of the u and v source components and their signs.
   typedef struct packed {
      axis_type u_axis;
      logic     u_neg;
      axis_type v_axis;
      logic     v_neg;
   } face_sel_type;

   function automatic face_sel_type face_sel(input logic [FACE_BITS-1:0] face);
      face_sel_type sel;
      unique case (face)
         FACE_POS_X: sel = '{u_axis: AXIS_Z, u_neg: 1'b1, v_axis: AXIS_Y, v_neg: 1'b1};
         FACE_NEG_X: sel = '{u_axis: AXIS_Z, u_neg: 1'b0, v_axis: AXIS_Y, v_neg: 1'b1};
         FACE_POS_Y: sel = '{u_axis: AXIS_X, u_neg: 1'b0, v_axis: AXIS_Z, v_neg: 1'b0};
         FACE_NEG_Y: sel = '{u_axis: AXIS_X, u_neg: 1'b0, v_axis: AXIS_Z, v_neg: 1'b1};
         FACE_POS_Z: sel = '{u_axis: AXIS_X, u_neg: 1'b0, v_axis: AXIS_Y, v_neg: 1'b1};
         FACE_NEG_Z: sel = '{u_axis: AXIS_X, u_neg: 1'b1, v_axis: AXIS_Y, v_neg: 1'b1};
         default:    sel = '{u_axis: AXIS_X, u_neg: 1'b0, v_axis: AXIS_Y, v_neg: 1'b0};
      endcase
      return sel;
   endfunction

endpackage

>>> hdl/cubemap_face_uv_project.sv
`timescale 1ns / 1ps
// Cube-map face selection and face u/v projection, fully pipelined.
// Depends on cfuv_pkg and instantiates cfuv_div.
//
//   Channel   Ports                      Handshake
//   --------  -------------------------  ---------------------------------------
//   request   start, busy, req_data      beat taken when start=1 and busy=0
//   response  rsp_strobe, rsp_data       beat valid for one cycle, cannot stall
//
// A new beat may be started every cycle; busy stays low.
// The pipeline registers are magnitude, axis select, numerator build, 17 divider
// stages (one quotient bit each, set by the u and v restoring divider), and
// the saturating output register.
// Reset clears only the valid bits of the pipeline; payload is not reset.
// Nothing stalls, so every started beat comes out exactly once, in order.
module cubemap_face_uv_project
   import cfuv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int LATENCY = QUO_BITS + 4;

   // Numerator m + s*c, clamped at zero; it lies in [0, 2m].
   function automatic logic [NUM_BITS-1:0] shifted_num(
      input logic [MAG_BITS-1:0]          mag,
      input logic signed [COORD_BITS-1:0] comp,
      input logic                         neg
   );
      logic signed [NUM_BITS:0] mag_s;
      logic signed [NUM_BITS:0] comp_s;
      logic signed [NUM_BITS:0] sum;
      mag_s  = {2'b00, mag};
      comp_s = {{(NUM_BITS + 1 - COORD_BITS){comp[COORD_BITS-1]}}, comp};
      sum    = neg ? (mag_s - comp_s) : (mag_s + comp_s);
      return sum[NUM_BITS] ? '0 : sum[NUM_BITS-1:0];
   endfunction

   logic accept;
   logic signed [COORD_BITS-1:0] dir_in [3];

   // Stage A: components and their magnitudes.
   logic                         a_valid_ff;
   logic signed [COORD_BITS-1:0] a_dir_ff [3];
   logic [MAG_BITS-1:0]          a_mag_ff [3];
   logic [MAG_BITS-1:0]          a_mag_in [3];

   // Stage B: face, major magnitude and chosen components.
   logic                         b_valid_ff;
   cfuv_tag_type                 b_tag_ff;
   cfuv_tag_type                 b_tag_in;
   logic [MAG_BITS-1:0]          b_mag_ff;
   logic signed [COORD_BITS-1:0] b_comp_u_ff;
   logic signed [COORD_BITS-1:0] b_comp_v_ff;
   logic                         b_neg_u_ff;
   logic                         b_neg_v_ff;
   axis_type                     axis;
   logic [FACE_BITS-1:0]         face_in;
   face_sel_type                 sel;

   // Stage C: dividends and divisor.
   logic                 c_valid_ff;
   cfuv_tag_type         c_tag_ff;
   logic [DIVD_BITS-1:0] c_num_u_ff;
   logic [DIVD_BITS-1:0] c_num_v_ff;
   logic [DIVS_BITS-1:0] c_den_ff;

   // Divider outputs.
   logic                div_valid;
   cfuv_tag_type        div_tag;
   logic [QUO_BITS-1:0] div_quo_u;
   logic [QUO_BITS-1:0] div_quo_v;

   // Output register.
   logic    rsp_strobe_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;

   // The pipeline never stalls, so a beat is taken whenever start is high.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign dir_in[0] = req_data.dir_x;
   assign dir_in[1] = req_data.dir_y;
   assign dir_in[2] = req_data.dir_z;

   // Magnitudes, one bit wider so the most negative value is exact.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (dir_in[i][COORD_BITS-1]) begin
            a_mag_in[i] = ~{dir_in[i][COORD_BITS-1], dir_in[i]} + 1'b1;
         end else begin
            a_mag_in[i] = {1'b0, dir_in[i]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= accept;
      end
      a_dir_ff <= dir_in;
      a_mag_ff <= a_mag_in;
   end

   // Major axis, with ties going to Z, then Y.
   always_comb begin
      priority if (a_mag_ff[2] >= a_mag_ff[0] && a_mag_ff[2] >= a_mag_ff[1]) begin
         axis = AXIS_Z;
      end else if (a_mag_ff[1] >= a_mag_ff[0]) begin
         axis = AXIS_Y;
      end else begin
         axis = AXIS_X;
      end
      face_in           = {axis, a_dir_ff[axis][COORD_BITS-1]};
      sel               = face_sel(face_in);
      b_tag_in.face     = face_in;
      b_tag_in.zero_dir = (a_mag_ff[0] == '0) && (a_mag_ff[1] == '0) && (a_mag_ff[2] == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      b_tag_ff    <= b_tag_in;
      b_mag_ff    <= a_mag_ff[axis];
      b_comp_u_ff <= a_dir_ff[sel.u_axis];
      b_comp_v_ff <= a_dir_ff[sel.v_axis];
      b_neg_u_ff  <= sel.u_neg;
      b_neg_v_ff  <= sel.v_neg;
   end

   // Dividend n * 2^UV_BITS + m rounds the quotient by 2m to nearest.
   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= b_valid_ff;
      end
      c_tag_ff   <= b_tag_ff;
      c_num_u_ff <= {shifted_num(b_mag_ff, b_comp_u_ff, b_neg_u_ff), {UV_BITS{1'b0}}}
                    + DIVD_BITS'(b_mag_ff);
      c_num_v_ff <= {shifted_num(b_mag_ff, b_comp_v_ff, b_neg_v_ff), {UV_BITS{1'b0}}}
                    + DIVD_BITS'(b_mag_ff);
      c_den_ff   <= {b_mag_ff, 1'b0};
   end

   cfuv_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_valid_ff),
      .in_tag    (c_tag_ff),
      .in_num_u  (c_num_u_ff),
      .in_num_v  (c_num_v_ff),
      .in_den    (c_den_ff),
      .out_valid (div_valid),
      .out_tag   (div_tag),
      .out_quo_u (div_quo_u),
      .out_quo_v (div_quo_v)
   );

   // Saturate a coordinate of exactly one to all ones; a zero vector reads centered.
   always_comb begin
      if (div_tag.zero_dir) begin
         rsp_data_in.face     = FACE_POS_Z;
         rsp_data_in.tex_u    = UV_HALF;
         rsp_data_in.tex_v    = UV_HALF;
         rsp_data_in.zero_dir = 1'b1;
      end else begin
         rsp_data_in.face     = div_tag.face;
         rsp_data_in.tex_u    = div_quo_u[QUO_BITS-1] ? UV_MAX : div_quo_u[UV_BITS-1:0];
         rsp_data_in.tex_v    = div_quo_v[QUO_BITS-1] ? UV_MAX : div_quo_v[UV_BITS-1:0];
         rsp_data_in.zero_dir = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= div_valid;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // Every result beat comes from a beat started a fixed latency earlier.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, LATENCY))
      else $error("result beat without a matching request beat");

   // The zero flag follows an all-zero request from the same beat.
   a_zero_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.zero_dir == $past(req_data == '0, LATENCY)))
      else $error("zero flag does not match the request beat");

   // The rounded quotient never passes one, since the numerator stays within 2m.
   a_quo_range: assert property (@(posedge clock) disable iff (reset)
      (div_valid && !div_tag.zero_dir) |->
         (!div_quo_u[QUO_BITS-1] || div_quo_u[UV_BITS-1:0] == '0) &&
         (!div_quo_v[QUO_BITS-1] || div_quo_v[UV_BITS-1:0] == '0))
      else $error("divider quotient out of range");

   // Only the six real face codes are reported.
   a_face_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.face <= FACE_NEG_Z))
      else $error("invalid face code");

endmodule

>>> hdl/cfuv_div.sv
`timescale 1ns / 1ps
// Two-lane pipelined restoring divider, one quotient bit per register stage.
// Depends on cfuv_pkg for widths and the sideband tag type.
module cfuv_div
   import cfuv_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  cfuv_tag_type         in_tag,
   input  logic [DIVD_BITS-1:0] in_num_u,
   input  logic [DIVD_BITS-1:0] in_num_v,
   input  logic [DIVS_BITS-1:0] in_den,
   output logic                 out_valid,
   output cfuv_tag_type         out_tag,
   output logic [QUO_BITS-1:0]  out_quo_u,
   output logic [QUO_BITS-1:0]  out_quo_v
);

   // One restoring step: returns {quotient bit, new remainder}.
   function automatic logic [DIVS_BITS:0] div_step(
      input logic [DIVS_BITS-1:0] rem,
      input logic                 bit_in,
      input logic [DIVS_BITS-1:0] den
   );
      logic [DIVS_BITS:0]   trial;
      logic [DIVS_BITS+1:0] diff;
      trial = {rem, bit_in};
      diff  = {1'b0, trial} - {2'b00, den};
      if (diff[DIVS_BITS+1]) begin
         return {1'b0, trial[DIVS_BITS-1:0]};
      end
      return {1'b1, diff[DIVS_BITS-1:0]};
   endfunction

   // Stage registers.
   logic                 valid_ff [QUO_BITS];
   cfuv_tag_type         tag_ff   [QUO_BITS];
   logic [DIVD_BITS-1:0] num_u_ff [QUO_BITS];
   logic [DIVD_BITS-1:0] num_v_ff [QUO_BITS];
   logic [DIVS_BITS-1:0] den_ff   [QUO_BITS];
   logic [DIVS_BITS-1:0] rem_u_ff [QUO_BITS];
   logic [DIVS_BITS-1:0] rem_v_ff [QUO_BITS];
   logic [QUO_BITS-1:0]  quo_u_ff [QUO_BITS];
   logic [QUO_BITS-1:0]  quo_v_ff [QUO_BITS];

   // What feeds each stage: the ports for the first, the previous stage otherwise.
   logic                 src_valid [QUO_BITS];
   cfuv_tag_type         src_tag   [QUO_BITS];
   logic [DIVD_BITS-1:0] src_num_u [QUO_BITS];
   logic [DIVD_BITS-1:0] src_num_v [QUO_BITS];
   logic [DIVS_BITS-1:0] src_den   [QUO_BITS];
   logic [DIVS_BITS-1:0] src_rem_u [QUO_BITS];
   logic [DIVS_BITS-1:0] src_rem_v [QUO_BITS];
   logic [QUO_BITS-1:0]  src_quo_u [QUO_BITS];
   logic [QUO_BITS-1:0]  src_quo_v [QUO_BITS];

   // Next values of the remainder and quotient registers.
   logic [DIVS_BITS:0]   step_u   [QUO_BITS];
   logic [DIVS_BITS:0]   step_v   [QUO_BITS];
   logic [QUO_BITS-1:0]  quo_u_in [QUO_BITS];
   logic [QUO_BITS-1:0]  quo_v_in [QUO_BITS];

   // The quotient fits in QUO_BITS, so the dividend above those bits is already
   // smaller than the divisor and serves as the starting remainder.
   always_comb begin
      src_valid[0] = in_valid;
      src_tag[0]   = in_tag;
      src_num_u[0] = in_num_u;
      src_num_v[0] = in_num_v;
      src_den[0]   = in_den;
      src_rem_u[0] = DIVS_BITS'(in_num_u[DIVD_BITS-1:QUO_BITS]);
      src_rem_v[0] = DIVS_BITS'(in_num_v[DIVD_BITS-1:QUO_BITS]);
      src_quo_u[0] = '0;
      src_quo_v[0] = '0;
      for (int s = 1; s < QUO_BITS; s++) begin
         src_valid[s] = valid_ff[s-1];
         src_tag[s]   = tag_ff[s-1];
         src_num_u[s] = num_u_ff[s-1];
         src_num_v[s] = num_v_ff[s-1];
         src_den[s]   = den_ff[s-1];
         src_rem_u[s] = rem_u_ff[s-1];
         src_rem_v[s] = rem_v_ff[s-1];
         src_quo_u[s] = quo_u_ff[s-1];
         src_quo_v[s] = quo_v_ff[s-1];
      end
   end

   // Stage s resolves quotient bit QUO_BITS-1-s for both lanes.
   always_comb begin
      for (int s = 0; s < QUO_BITS; s++) begin
         step_u[s]   = div_step(src_rem_u[s], src_num_u[s][QUO_BITS-1-s], src_den[s]);
         step_v[s]   = div_step(src_rem_v[s], src_num_v[s][QUO_BITS-1-s], src_den[s]);
         quo_u_in[s] = src_quo_u[s];
         quo_v_in[s] = src_quo_v[s];
         quo_u_in[s][QUO_BITS-1-s] = step_u[s][DIVS_BITS];
         quo_v_in[s][QUO_BITS-1-s] = step_v[s][DIVS_BITS];
      end
   end

   // Valid bits are cleared by reset; the payload follows without reset.
   always_ff @(posedge clock) begin
      for (int s = 0; s < QUO_BITS; s++) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= src_valid[s];
         end
         tag_ff[s]   <= src_tag[s];
         num_u_ff[s] <= src_num_u[s];
         num_v_ff[s] <= src_num_v[s];
         den_ff[s]   <= src_den[s];
         rem_u_ff[s] <= step_u[s][DIVS_BITS-1:0];
         rem_v_ff[s] <= step_v[s][DIVS_BITS-1:0];
         quo_u_ff[s] <= quo_u_in[s];
         quo_v_ff[s] <= quo_v_in[s];
      end
   end

   assign out_valid = valid_ff[QUO_BITS-1];
   assign out_tag   = tag_ff[QUO_BITS-1];
   assign out_quo_u = quo_u_ff[QUO_BITS-1];
   assign out_quo_v = quo_v_ff[QUO_BITS-1];

endmodule

>>> tb/sv/cubemap_face_uv_project_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the cube-map face projector: watches both channels, predicts
// each result from the accepted direction and compares field by field.
// Depends on cfuv_pkg for the beat types, face codes and widths.
module cubemap_face_uv_project_checker
   import cfuv_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  req_type           req_data,
   input  logic              rsp_strobe,
   input  rsp_type           rsp_data,
   output int unsigned       mismatch_count,
   output int unsigned       pending_count,
   output int unsigned       checked_count,
   output int unsigned       zero_count,
   output logic        [5:0] faces_seen
);

   typedef struct {
      req_type dir;
      rsp_type rsp;
   } projection_type;

   projection_type projections_due[$];

   // One face coordinate: 1/2 + s*c/(2m), rounded half up and saturated.
   function automatic logic [UV_BITS-1:0] face_coord(input longint c, input bit negate,
                                                     input longint m);
      longint n;
      longint q;
      n = negate ? m - c : m + c;
      if (n < 0) n = 0;
      q = ((n << UV_BITS) + m) / (2 * m);
      if (q > longint'(UV_MAX)) return UV_MAX;
      return q[UV_BITS-1:0];
   endfunction

   // Major axis, face and u/v for one direction.
   function automatic rsp_type project_dir(input req_type dir);
      longint   comp [3];
      longint   mag [3];
      axis_type major;
      axis_type u_axis;
      axis_type v_axis;
      bit       u_neg;
      bit       v_neg;
      bit       negative;
      rsp_type  r;
      comp[AXIS_X] = $signed(dir.dir_x);
      comp[AXIS_Y] = $signed(dir.dir_y);
      comp[AXIS_Z] = $signed(dir.dir_z);
      for (int i = 0; i < 3; i++) mag[i] = (comp[i] < 0) ? -comp[i] : comp[i];

      if (mag[AXIS_X] == 0 && mag[AXIS_Y] == 0 && mag[AXIS_Z] == 0) begin
         r.face     = FACE_POS_Z;
         r.tex_u    = UV_HALF;
         r.tex_v    = UV_HALF;
         r.zero_dir = 1'b1;
         return r;
      end

      // Ties go to Z first, then Y.
      if (mag[AXIS_Z] >= mag[AXIS_X] && mag[AXIS_Z] >= mag[AXIS_Y]) major = AXIS_Z;
      else if (mag[AXIS_Y] >= mag[AXIS_X]) major = AXIS_Y;
      else major = AXIS_X;
      negative = comp[major] < 0;

      case (major)
         AXIS_X: r.face = negative ? FACE_NEG_X : FACE_POS_X;
         AXIS_Y: r.face = negative ? FACE_NEG_Y : FACE_POS_Y;
         default: r.face = negative ? FACE_NEG_Z : FACE_POS_Z;
      endcase

      // Source component and sign of u and v on each face.
      case (r.face)
         FACE_POS_X: begin
            u_axis = AXIS_Z; u_neg = 1'b1; v_axis = AXIS_Y; v_neg = 1'b1;
         end
         FACE_NEG_X: begin
            u_axis = AXIS_Z; u_neg = 1'b0; v_axis = AXIS_Y; v_neg = 1'b1;
         end
         FACE_POS_Y: begin
            u_axis = AXIS_X; u_neg = 1'b0; v_axis = AXIS_Z; v_neg = 1'b0;
         end
         FACE_NEG_Y: begin
            u_axis = AXIS_X; u_neg = 1'b0; v_axis = AXIS_Z; v_neg = 1'b1;
         end
         FACE_POS_Z: begin
            u_axis = AXIS_X; u_neg = 1'b0; v_axis = AXIS_Y; v_neg = 1'b1;
         end
         default: begin
            u_axis = AXIS_X; u_neg = 1'b1; v_axis = AXIS_Y; v_neg = 1'b1;
         end
      endcase

      r.tex_u    = face_coord(comp[u_axis], u_neg, mag[major]);
      r.tex_v    = face_coord(comp[v_axis], v_neg, mag[major]);
      r.zero_dir = 1'b0;
      return r;
   endfunction

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
      checked_count  = 0;
      zero_count     = 0;
      faces_seen     = '0;
   end

   // Compare each result beat with the oldest prediction, then log new requests.
   always @(posedge clock) begin
      projection_type due;
      int unsigned    errs;
      errs = mismatch_count;
      if (!reset) begin
         if (rsp_strobe) begin
            if (projections_due.size() == 0) begin
               $error("result beat with no request outstanding: face %0d u %0d v %0d zero %0b",
                      rsp_data.face, rsp_data.tex_u, rsp_data.tex_v, rsp_data.zero_dir);
               errs++;
            end else begin
               due = projections_due.pop_front();
               if (rsp_data.face !== due.rsp.face) begin
                  $error("face: expected %0d, got %0d (dir %0d %0d %0d)", due.rsp.face,
                         rsp_data.face, due.dir.dir_x, due.dir.dir_y, due.dir.dir_z);
                  errs++;
               end
               if (rsp_data.tex_u !== due.rsp.tex_u) begin
                  $error("tex_u: expected %0d, got %0d (dir %0d %0d %0d)", due.rsp.tex_u,
                         rsp_data.tex_u, due.dir.dir_x, due.dir.dir_y, due.dir.dir_z);
                  errs++;
               end
               if (rsp_data.tex_v !== due.rsp.tex_v) begin
                  $error("tex_v: expected %0d, got %0d (dir %0d %0d %0d)", due.rsp.tex_v,
                         rsp_data.tex_v, due.dir.dir_x, due.dir.dir_y, due.dir.dir_z);
                  errs++;
               end
               if (rsp_data.zero_dir !== due.rsp.zero_dir) begin
                  $error("zero_dir: expected %0b, got %0b (dir %0d %0d %0d)", due.rsp.zero_dir,
                         rsp_data.zero_dir, due.dir.dir_x, due.dir.dir_y, due.dir.dir_z);
                  errs++;
               end
               checked_count <= checked_count + 1;
               if (due.rsp.zero_dir) zero_count <= zero_count + 1;
               else faces_seen[due.rsp.face] <= 1'b1;
            end
         end
         if (start && !busy) begin
            due.dir = req_data;
            due.rsp = project_dir(req_data);
            projections_due.push_back(due);
         end
      end
      mismatch_count <= errs;
      pending_count  <= projections_due.size();
   end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the cube-map face projector testbench: clock, reset, direction stimulus
// and the verdict. Depends on cfuv_pkg, cubemap_face_uv_project and its checker.
module testbench;
   import cfuv_pkg::*;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_data;
   logic        rsp_strobe;
   rsp_type     rsp_data;

   int unsigned mismatch_count;
   int unsigned pending_count;
   int unsigned checked_count;
   int unsigned zero_count;
   logic  [5:0] faces_seen;
   int unsigned sent_count;

   localparam int RANDOM_PER_PHASE = 445;
   localparam int DRAIN_CYCLES     = 30;
   localparam int CORNER_VALS [8]  = '{-32768, -32767, -16384, -1, 0, 1, 16384, 32767};

   cubemap_face_uv_project dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   cubemap_face_uv_project_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count),
      .zero_count     (zero_count),
      .faces_seen     (faces_seen)
   );

   // 100 MHz clock.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offer one direction beat after a random number of idle cycles and wait
   // until it is taken.
   task automatic send_dir(input int x, input int y, input int z, input int idle_pct);
      req_type beat;
      beat.dir_x = COORD_BITS'(x);
      beat.dir_y = COORD_BITS'(y);
      beat.dir_z = COORD_BITS'(z);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent_count++;
   endtask

   // Hold off the sender until every outstanding result has come back.
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Random direction: full-range in four of ten picks, with small vectors, corner values and
   // forced magnitude ties mixed in so the tie-break and saturation paths get hit.
   task automatic pick_dir(output int x, output int y, output int z);
      int comp [3];
      int mag;
      int a;
      int b;
      case ($urandom_range(9))
         0, 1, 2, 3: begin
            for (int i = 0; i < 3; i++) comp[i] = $signed(COORD_BITS'($urandom));
         end
         4, 5: begin
            for (int i = 0; i < 3; i++) comp[i] = int'($urandom_range(8)) - 4;
         end
         6: begin
            for (int i = 0; i < 3; i++) comp[i] = CORNER_VALS[$urandom_range(7)];
         end
         default: begin
            mag = $urandom_range(32767, 1);
            a   = $urandom_range(2);
            b   = (a + 1 + $urandom_range(1)) % 3;
            for (int i = 0; i < 3; i++) begin
               if (i == a || i == b) comp[i] = mag;
               else comp[i] = $urandom_range(mag);
               if ($urandom_range(1)) comp[i] = -comp[i];
            end
         end
      endcase
      x = comp[0];
      y = comp[1];
      z = comp[2];
   endtask

   // Run limit, far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("testbench: errors");
      $finish;
   end

   initial begin
      int x;
      int y;
      int z;
      int idle_pct;
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      sent_count = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats: zero vector, full scale on every face, the most negative
      // component, tie-breaks, and u/v at both ends of their range.
      send_dir(0, 0, 0, 14);
      send_dir(32767, 0, 0, 14);
      send_dir(-32768, 0, 0, 14);
      send_dir(0, 32767, 0, 14);
      send_dir(0, -32768, 0, 14);
      send_dir(0, 0, 32767, 14);
      send_dir(0, 0, -32768, 14);
      send_dir(-32768, -32768, -32768, 14);
      send_dir(32767, 32767, 32767, 14);
      send_dir(1000, 1000, 1000, 14);
      send_dir(-700, 700, 5, 14);
      send_dir(700, -700, -5, 14);
      send_dir(-32768, 32767, 0, 14);
      send_dir(32767, -32768, 12345, 14);
      send_dir(1000, -1000, 1000, 0);
      send_dir(-1000, 0, 1000, 0);
      send_dir(1, 0, 0, 0);
      send_dir(0, -1, 0, 0);
      send_dir(0, 0, -1, 0);
      send_dir(3, 1, 2, 0);
      send_dir(-3, -1, 2, 0);
      send_dir(100, -32768, 32767, 0);
      send_dir(-32767, 16384, -16384, 0);
      send_dir(-32768, 0, 32767, 0);
      drain_results();

      // Random beats in three idle regimes, draining in between.
      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 14 : (phase == 1) ? 75 : 0;
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            pick_dir(x, y, z);
            send_dir(x, y, z, idle_pct);
         end
         drain_results();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Run: %0d directions sent, %0d projections checked, %0d zero vectors,",
               sent_count, checked_count, zero_count);
      $display("     faces reached (5..0) %b, idle at 14%%, 75%% and 0%% of cycles.", faces_seen);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

>>> cubemap_face_uv_project.f
hdl/cfuv_pkg.sv
hdl/cfuv_div.sv
hdl/cubemap_face_uv_project.sv
tb/sv/cubemap_face_uv_project_checker.sv
tb/sv/testbench.sv
